// ----- hdl/lsge_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lsge_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_W = 13;
    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 13'd4096;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam int COLOUR_W = 24;
    localparam int LABEL_W  = 24;
    localparam int LINE_W   = COLOUR_W + LABEL_W + 1;
    localparam logic [LABEL_W-1:0] LABEL_INVALID = 24'hFFFFFF;

    localparam int COORD_W = 12;
    localparam int DIFF_W  = 9;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic DIR_HORIZONTAL = 1'b0;
    localparam logic DIR_VERTICAL   = 1'b1;

    typedef struct packed {
        logic                     valid;
        logic [LABEL_W-1:0]       label;
        logic [COLOUR_W-1:0]      colour;
    } line_entry_t;

    typedef struct packed {
        logic [COORD_W-1:0]       edge_col;
        logic [COORD_W-1:0]       edge_row;
        logic                     direction;
        logic signed [DIFF_W-1:0] diff_red;
        logic signed [DIFF_W-1:0] diff_green;
        logic signed [DIFF_W-1:0] diff_blue;
        logic                     last;
    } result_t;

    function automatic logic signed [DIFF_W-1:0] byte_diff(input logic [7:0] newer,
                                                           input logic [7:0] older);
        byte_diff = $signed({1'b0, newer}) - $signed({1'b0, older});
    endfunction

endpackage
`default_nettype wire

// ----- hdl/lsge_line_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lsge_line_store #(
    parameter int DEPTH = lsge_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                  aclk,
    input  wire                  en,
    input  wire [AW-1:0]         addr,
    input  lsge_pkg::line_entry_t wr_data,
    output lsge_pkg::line_entry_t rd_data
);

    lsge_pkg::line_entry_t mem [DEPTH];

    // read-first: a read and write of one entry in one cycle returns the old word
    always_ff @(posedge aclk) begin
        if (en) begin
            rd_data   <= mem[addr];
            mem[addr] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/lsge_seam.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lsge_seam #(
    parameter int COL_W = 12,
    parameter int ROW_W = 12
) (
    input  wire [lsge_pkg::COLOUR_W-1:0] cur_colour,
    input  wire [lsge_pkg::LABEL_W-1:0]  cur_label,
    input  wire                          cur_valid,
    input  wire [lsge_pkg::COLOUR_W-1:0] left_colour,
    input  wire [lsge_pkg::LABEL_W-1:0]  left_label,
    input  wire                          left_valid,
    input  lsge_pkg::line_entry_t        up,
    input  wire [COL_W-1:0]              col,
    input  wire [ROW_W-1:0]              row,
    output lsge_pkg::result_t            item0,
    output lsge_pkg::result_t            item1,
    output logic [1:0]                   count
);

    logic              h_hit;
    logic              v_hit;
    lsge_pkg::result_t h_res;
    lsge_pkg::result_t v_res;
    logic [COL_W-1:0]  col_m1;
    logic [ROW_W-1:0]  row_m1;

    assign col_m1 = col - COL_W'(1);
    assign row_m1 = row - ROW_W'(1);

    assign h_hit = (col != '0) && left_valid && cur_valid && (left_label != cur_label);
    assign v_hit = (row != '0) && up.valid && cur_valid && (up.label != cur_label);

    always_comb begin
        h_res            = '0;
        h_res.edge_col   = lsge_pkg::COORD_W'(col_m1);
        h_res.edge_row   = lsge_pkg::COORD_W'(row);
        h_res.direction  = lsge_pkg::DIR_HORIZONTAL;
        h_res.diff_red   = lsge_pkg::byte_diff(cur_colour[23:16], left_colour[23:16]);
        h_res.diff_green = lsge_pkg::byte_diff(cur_colour[15:8], left_colour[15:8]);
        h_res.diff_blue  = lsge_pkg::byte_diff(cur_colour[7:0], left_colour[7:0]);
        h_res.last       = !v_hit;

        v_res            = '0;
        v_res.edge_col   = lsge_pkg::COORD_W'(col);
        v_res.edge_row   = lsge_pkg::COORD_W'(row_m1);
        v_res.direction  = lsge_pkg::DIR_VERTICAL;
        v_res.diff_red   = lsge_pkg::byte_diff(cur_colour[23:16], up.colour[23:16]);
        v_res.diff_green = lsge_pkg::byte_diff(cur_colour[15:8], up.colour[15:8]);
        v_res.diff_blue  = lsge_pkg::byte_diff(cur_colour[7:0], up.colour[7:0]);
        v_res.last       = 1'b1;
    end

    assign item0 = h_hit ? h_res : v_res;
    assign item1 = v_res;
    assign count = {1'b0, h_hit} + {1'b0, v_hit};

endmodule
`default_nettype wire

// ----- hdl/lsge_result_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lsge_result_fifo (
    input  wire                aclk,
    input  wire                aresetn,
    input  lsge_pkg::result_t  push_item0,
    input  lsge_pkg::result_t  push_item1,
    input  wire  [1:0]         push_count,
    output lsge_pkg::result_t  head,
    output logic               head_valid,
    input  wire                pop,
    output logic [lsge_pkg::FIFO_AW:0] fill
);

    lsge_pkg::result_t                 entries [lsge_pkg::FIFO_DEPTH];
    logic [lsge_pkg::FIFO_AW-1:0]      wr_ptr_reg;
    logic [lsge_pkg::FIFO_AW-1:0]      rd_ptr_reg;
    logic [lsge_pkg::FIFO_AW:0]        count_reg;
    logic [lsge_pkg::FIFO_AW:0]        count_next;
    logic                              do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign count_next = count_reg + (lsge_pkg::FIFO_AW+1)'(push_count)
                        - (lsge_pkg::FIFO_AW+1)'(do_pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + lsge_pkg::FIFO_AW'(push_count);
            rd_ptr_reg <= rd_ptr_reg + lsge_pkg::FIFO_AW'(do_pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            entries[wr_ptr_reg] <= push_item0;
        end
        if (push_count == 2'd2) begin
            entries[wr_ptr_reg + lsge_pkg::FIFO_AW'(1)] <= push_item1;
        end
    end

    assign head       = entries[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign fill       = count_reg;

endmodule
`default_nettype wire

// ----- hdl/label_seam_gradient_extract.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  word fields (lsb first)
// s_        in         red[7:0] green[7:0] blue[7:0] label[23:0]
// m_        out        edge_col edge_row diff_red diff_green diff_blue; tuser direction;
//                      tlast last
// cfg_      in         write: index 0 image_width, index 1 image_height
//
// A pixel is accepted, reads the line store at the same edge and yields its results
// in the next cycle into a four-word result queue; the queue drains one word per
// cycle while m_tready is high. The input stalls while the queue, counting the words
// the pixel in flight may still add, has fewer than two free entries, so pixels that
// yield seams slow the input down.
// Reset clears counters, left pixel and queue; the line store holds no reset value.
module label_seam_gradient_extract #(
    parameter int MAX_WIDTH  = lsge_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lsge_pkg::DEF_MAX_HEIGHT
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // red, green, blue, label
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // edge_col, edge_row, diff_red, diff_green, diff_blue, pad
    output logic [0:0]  m_tuser,   // direction
    output logic        m_tlast,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [lsge_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WCMP  = (lsge_pkg::CFG_W > COL_W + 1) ? lsge_pkg::CFG_W : COL_W + 1;
    localparam int HCMP  = (lsge_pkg::CFG_W > ROW_W + 1) ? lsge_pkg::CFG_W : ROW_W + 1;

    logic [lsge_pkg::CFG_W-1:0]  image_width_reg;
    logic [lsge_pkg::CFG_W-1:0]  image_height_reg;

    logic [COL_W-1:0]            col_reg;
    logic [COL_W-1:0]            col_next;
    logic [ROW_W-1:0]            row_reg;
    logic [ROW_W-1:0]            row_next;

    logic [lsge_pkg::COLOUR_W-1:0] left_colour_reg;
    logic [lsge_pkg::LABEL_W-1:0]  left_label_reg;
    logic                          left_valid_reg;

    logic                          s1_valid_reg;
    logic [lsge_pkg::COLOUR_W-1:0] s1_colour_reg;
    logic [lsge_pkg::LABEL_W-1:0]  s1_label_reg;
    logic                          s1_cur_valid_reg;
    logic [lsge_pkg::COLOUR_W-1:0] s1_left_colour_reg;
    logic [lsge_pkg::LABEL_W-1:0]  s1_left_label_reg;
    logic                          s1_left_valid_reg;
    logic [COL_W-1:0]              s1_col_reg;
    logic [ROW_W-1:0]              s1_row_reg;

    logic [WCMP-1:0]             w_raw;
    logic [WCMP-1:0]             w_eff;
    logic [WCMP-1:0]             col_inc;
    logic [HCMP-1:0]             h_raw;
    logic [HCMP-1:0]             h_eff;
    logic [HCMP-1:0]             row_inc;

    logic                          accept;
    logic [lsge_pkg::COLOUR_W-1:0] in_colour;
    logic [lsge_pkg::LABEL_W-1:0]  in_label;
    logic                          in_valid;
    lsge_pkg::line_entry_t         wr_entry;
    lsge_pkg::line_entry_t         up_entry;

    lsge_pkg::result_t           item0;
    lsge_pkg::result_t           item1;
    logic [1:0]                  seam_count;
    logic [1:0]                  push_count;
    lsge_pkg::result_t           head;
    logic [lsge_pkg::FIFO_AW:0]  fill;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= lsge_pkg::CFG_DIM_RESET;
            image_height_reg <= lsge_pkg::CFG_DIM_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                lsge_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                lsge_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_raw = WCMP'(image_width_reg);
    assign h_raw = HCMP'(image_height_reg);
    assign w_eff = (w_raw == '0) ? WCMP'(1) :
                   (w_raw > WCMP'(MAX_WIDTH)) ? WCMP'(MAX_WIDTH) : w_raw;
    assign h_eff = (h_raw == '0) ? HCMP'(1) :
                   (h_raw > HCMP'(MAX_HEIGHT)) ? HCMP'(MAX_HEIGHT) : h_raw;

    assign col_inc = WCMP'(col_reg) + WCMP'(1);
    assign row_inc = HCMP'(row_reg) + HCMP'(1);

    always_comb begin
        col_next = COL_W'(col_inc);
        row_next = row_reg;
        if (col_inc >= w_eff) begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : ROW_W'(row_inc);
        end
    end

    assign in_colour = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    assign in_label  = s_tdata[47:24];
    assign in_valid  = (in_label != lsge_pkg::LABEL_INVALID);

    assign wr_entry.valid  = in_valid;
    assign wr_entry.label  = in_label;
    assign wr_entry.colour = in_colour;

    // hold input until the queue can absorb two words from the next pixel
    assign s_tready = (fill == '0) ||
                      (!s1_valid_reg && (fill <= (lsge_pkg::FIFO_AW+1)'(2)));
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg         <= '0;
            row_reg         <= '0;
            left_colour_reg <= '0;
            left_label_reg  <= '0;
            left_valid_reg  <= 1'b0;
            s1_valid_reg    <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                col_reg         <= col_next;
                row_reg         <= row_next;
                left_colour_reg <= in_colour;
                left_label_reg  <= in_label;
                left_valid_reg  <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_colour_reg      <= in_colour;
            s1_label_reg       <= in_label;
            s1_cur_valid_reg   <= in_valid;
            s1_left_colour_reg <= left_colour_reg;
            s1_left_label_reg  <= left_label_reg;
            s1_left_valid_reg  <= left_valid_reg;
            s1_col_reg         <= col_reg;
            s1_row_reg         <= row_reg;
        end
    end

    lsge_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_store (
        .aclk    (aclk),
        .en      (accept),
        .addr    (col_reg),
        .wr_data (wr_entry),
        .rd_data (up_entry)
    );

    lsge_seam #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_seam (
        .cur_colour  (s1_colour_reg),
        .cur_label   (s1_label_reg),
        .cur_valid   (s1_cur_valid_reg),
        .left_colour (s1_left_colour_reg),
        .left_label  (s1_left_label_reg),
        .left_valid  (s1_left_valid_reg),
        .up          (up_entry),
        .col         (s1_col_reg),
        .row         (s1_row_reg),
        .item0       (item0),
        .item1       (item1),
        .count       (seam_count)
    );

    assign push_count = s1_valid_reg ? seam_count : 2'd0;

    lsge_result_fifo u_result_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_item0 (item0),
        .push_item1 (item1),
        .push_count (push_count),
        .head       (head),
        .head_valid (m_tvalid),
        .pop        (m_tready),
        .fill       (fill)
    );

    assign m_tdata = {5'd0, head.diff_blue, head.diff_green, head.diff_red,
                      head.edge_row, head.edge_col};
    assign m_tuser = head.direction;
    assign m_tlast = head.last;

endmodule
`default_nettype wire
